// ----- sv/assert_macros.svh -----
// Assertion macros used by the cluster table engine sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while reset is held.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fct: same-cycle check failed");

// Next-cycle implication, clocked on i_clk, off while reset is held.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fct: next-cycle check failed");

`endif

// ----- sv/fct_pkg.sv -----
// Types, codes and helpers shared by the cluster table engine.
`default_nettype none

package fct_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = 12;
    localparam int LEN_W       = 13;
    localparam int KIND_W      = 2;
    localparam int OP_W        = 3;
    localparam int STAT_W      = 3;

    localparam logic [LEN_W-1:0] TABLE_DEPTH_L = LEN_W'(TABLE_DEPTH);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_READ  = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK = 3'd4;

    // Entry kinds
    localparam logic [KIND_W-1:0] KIND_LINK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_CAP   = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  next;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  cluster_out;
        logic [KIND_W-1:0] kind_out;
        logic [IDX_W-1:0]  next_out;
        logic [LEN_W-1:0]  chain_length;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        t_entry             wdata;
        logic [IDX_W-1:0]   raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_WRITE,
        S_READ,
        S_WALK,
        S_RESULT
    } t_state;

    // Only a link keeps its next index.
    function automatic t_entry make_entry(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] next);
        t_entry e;
        e.kind = kind;
        e.next = (kind == KIND_LINK) ? next : '0;
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- sv/fct_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
`default_nettype none

module fct_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/fct_seq.sv -----
// Sequencer: clears the table, then runs each operation as reads and writes on the table RAM.
`default_nettype none
`include "assert_macros.svh"

module fct_seq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [fct_pkg::OP_W-1:0]  i_op,
    input  wire logic [fct_pkg::IDX_W-1:0] i_cluster,
    input  wire logic [fct_pkg::KIND_W-1:0] i_entry_kind,
    input  wire logic [fct_pkg::IDX_W-1:0] i_entry_next,
    input  wire logic [fct_pkg::LEN_W-1:0] i_cfg_size,
    output fct_pkg::t_ram_req              o_ram_req,
    input  wire logic [fct_pkg::ENTRY_W-1:0] i_ram_rdata,
    output logic                           o_res_valid,
    input  wire logic                      i_res_take,
    output fct_pkg::t_result               o_res
);

    import fct_pkg::*;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr, n_clr;
    logic               r_fwd, n_fwd;
    logic [OP_W-1:0]    r_op, n_op;
    logic [IDX_W-1:0]   r_cl, n_cl;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [IDX_W-1:0]   r_next, n_next;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [LEN_W-1:0]   r_count, n_count;
    t_result            r_res, n_res;

    logic [LEN_W-1:0]   eff_size;
    t_entry             ent;
    logic               cl_oob, ptr_oob, ptr_last, next_oob, cap_hit, is_free;
    logic [IDX_W-1:0]   ptr_inc;
    logic [LEN_W-1:0]   cnt_inc;
    logic               walk_stop;
    logic [STAT_W-1:0]  walk_status;
    logic               wr_en;

    // Effective table size, limited to the RAM depth
    assign eff_size = (i_cfg_size > TABLE_DEPTH_L) ? TABLE_DEPTH_L : i_cfg_size;

    // A free walk may revisit the entry it just cleared; forward the cleared value
    assign ent = r_fwd ? make_entry(KIND_UNUSED, '0) : t_entry'(i_ram_rdata);

    assign cl_oob   = {1'b0, r_cl} >= eff_size;
    assign ptr_oob  = {1'b0, r_ptr} >= eff_size;
    assign ptr_inc  = r_ptr + IDX_W'(1);
    assign ptr_last = ({1'b0, r_ptr} + LEN_W'(1)) >= eff_size;
    assign next_oob = {1'b0, ent.next} >= eff_size;
    assign cnt_inc  = r_count + LEN_W'(1);
    assign cap_hit  = cnt_inc >= eff_size;
    assign is_free  = (r_op == OP_FREE);

    always_comb begin
        walk_stop   = 1'b1;
        walk_status = STAT_OK;
        if (!is_free && ent.kind == KIND_BAD) begin
            walk_status = STAT_BAD;
        end else if (ent.kind != KIND_LINK) begin
            walk_status = STAT_OK;
        end else if (next_oob) begin
            walk_status = STAT_RANGE;
        end else if (cap_hit) begin
            walk_status = STAT_CAP;
        end else begin
            walk_stop = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_op)
                        OP_ALLOC:           n_state = S_ALLOC;
                        OP_WRITE:           n_state = S_WRITE;
                        OP_READ:            n_state = S_READ;
                        OP_FREE, OP_CHECK:  n_state = S_WALK;
                        default:            n_state = S_RESULT;
                    endcase
                end
            end
            S_ALLOC: begin
                if (ptr_oob || ent.kind == KIND_UNUSED || ptr_last) n_state = S_RESULT;
            end
            S_WRITE:  n_state = S_RESULT;
            S_READ:   n_state = S_RESULT;
            S_WALK: begin
                if (ptr_oob || walk_stop) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_take) n_state = S_IDLE;
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    // Outputs: handshake and RAM port control
    always_comb begin
        o_stall     = (r_state != S_IDLE);
        o_res_valid = (r_state == S_RESULT);
        wr_en       = 1'b0;
        o_ram_req.waddr = r_ptr;
        o_ram_req.wdata = make_entry(KIND_UNUSED, '0);
        o_ram_req.raddr = r_ptr;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                o_ram_req.waddr = r_clr;
            end
            S_IDLE: begin
                o_ram_req.raddr = (i_op == OP_ALLOC) ? IDX_W'(1) : i_cluster;
            end
            S_ALLOC: begin
                wr_en = !ptr_oob && ent.kind == KIND_UNUSED;
                o_ram_req.wdata = make_entry(KIND_END, '0);
                o_ram_req.raddr = ptr_inc;
            end
            S_WRITE: begin
                wr_en = !cl_oob;
                o_ram_req.waddr = r_cl;
                o_ram_req.wdata = make_entry(r_kind, r_next);
            end
            S_WALK: begin
                wr_en = is_free && !ptr_oob;
                o_ram_req.raddr = ent.next;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        o_ram_req.we = wr_en;
        o_res = r_res;
    end

    // Datapath next values
    always_comb begin
        n_clr   = r_clr;
        n_op    = r_op;
        n_cl    = r_cl;
        n_kind  = r_kind;
        n_next  = r_next;
        n_ptr   = r_ptr;
        n_count = r_count;
        n_res   = r_res;
        n_fwd   = (r_state == S_WALK) && wr_en && (o_ram_req.raddr == o_ram_req.waddr);
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + IDX_W'(1);
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_op;
                    n_cl    = i_cluster;
                    n_kind  = i_entry_kind;
                    n_next  = i_entry_next;
                    n_ptr   = (i_op == OP_ALLOC) ? IDX_W'(1) : i_cluster;
                    n_count = '0;
                    n_res   = '0;
                end
            end
            S_ALLOC: begin
                if (ptr_oob) begin
                    n_res.status = STAT_FULL;
                end else if (ent.kind == KIND_UNUSED) begin
                    n_res.cluster_out = r_ptr;
                    n_res.status      = STAT_OK;
                end else if (ptr_last) begin
                    n_res.status = STAT_FULL;
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            S_WRITE: begin
                if (cl_oob) n_res.status = STAT_RANGE;
            end
            S_READ: begin
                if (cl_oob) begin
                    n_res.status = STAT_RANGE;
                end else begin
                    n_res.kind_out = ent.kind;
                    n_res.next_out = ent.next;
                end
            end
            S_WALK: begin
                if (ptr_oob) begin
                    n_res.status       = STAT_RANGE;
                    n_res.chain_length = '0;
                end else if (walk_stop) begin
                    n_res.status       = walk_status;
                    n_res.chain_length = cnt_inc;
                end else begin
                    n_ptr   = ent.next;
                    n_count = cnt_inc;
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_fwd   <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_cl    <= n_cl;
        r_kind  <= n_kind;
        r_next  <= n_next;
        r_ptr   <= n_ptr;
        r_count <= n_count;
        r_res   <= n_res;
    end

    `ASSERT_SAME(a_no_write_when_waiting, (r_state == S_IDLE) || (r_state == S_RESULT), !wr_en)
    `ASSERT_SAME(a_walk_count_below_size, (r_state == S_WALK) && (r_count != '0), r_count < eff_size)
    `ASSERT_SAME(a_scan_skips_zero, r_state == S_ALLOC, r_ptr != '0)
    `ASSERT_NEXT(a_single_access_done, (r_state == S_WRITE) || (r_state == S_READ), r_state == S_RESULT)

endmodule

`default_nettype wire

// ----- sv/fat_cluster_table_engine.sv -----
// Top level of the cluster table engine: size register, table RAM, sequencer, result register.
`default_nettype none

// After reset the block sweeps the 4096-entry table to unused, one entry per cycle, and
// holds o_stall high throughout it; size writes are taken during the sweep.
// Items are then handled one at a time against a single table RAM with a registered read,
// which visits one entry per cycle. An allocate scans entries upward from index 1 for an
// unused one; free and check follow the chain from the given cluster, and a start out of
// range gives a range status; read and write access one entry, an unknown op none. A
// finished result sits in an output register, so the next item is taken while it waits.
module fat_cluster_table_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [fct_pkg::OP_W-1:0]    i_op,
    input  wire logic [fct_pkg::IDX_W-1:0]   i_cluster,
    input  wire logic [fct_pkg::KIND_W-1:0]  i_entry_kind,
    input  wire logic [fct_pkg::IDX_W-1:0]   i_entry_next,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [fct_pkg::STAT_W-1:0]       o_status,
    output logic [fct_pkg::IDX_W-1:0]        o_cluster_out,
    output logic [fct_pkg::KIND_W-1:0]       o_kind_out,
    output logic [fct_pkg::IDX_W-1:0]        o_next_out,
    output logic [fct_pkg::LEN_W-1:0]        o_chain_length,
    input  wire logic                        i_cfg_we,
    input  wire logic [fct_pkg::LEN_W-1:0]   i_cfg_data
);

    import fct_pkg::*;

    logic [LEN_W-1:0]   r_cfg;
    logic               r_out_valid;
    t_result            r_out;
    t_ram_req           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               res_valid;
    logic               res_take;
    t_result            res;

    fct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    fct_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_cluster    (i_cluster),
        .i_entry_kind (i_entry_kind),
        .i_entry_next (i_entry_next),
        .i_cfg_size   (r_cfg),
        .o_ram_req    (ram_req),
        .i_ram_rdata  (ram_rdata),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    // Load a new result when the slot is empty or its beat leaves this cycle
    assign res_take = res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= TABLE_DEPTH_L;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) r_out <= res;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_cluster_out  = r_out.cluster_out;
    assign o_kind_out     = r_out.kind_out;
    assign o_next_out     = r_out.next_out;
    assign o_chain_length = r_out.chain_length;

endmodule

`default_nettype wire
